### rtl/pxa_pkg.sv
// Shared constants, types and lookup functions for the pixel-to-glyph colour unit.
package pxa_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int unsigned CHAN_MAX = (1 << CHANNEL_BITS) - 1;
   localparam int DIFF_W = CHANNEL_BITS + 2;
   localparam int BASE_W = 2 * CHANNEL_BITS;
   localparam int SHADE_W = 2 * CHANNEL_BITS + 4;
   localparam int RAMP_LEN = 12;
   localparam int GRAD_W = 11;
   localparam int THR_W = 11;
   localparam int SQ_W = 2 * GRAD_W;
   localparam int SUM_W = GRAD_W + 1;
   localparam int SUM_SQ_W = 2 * SUM_W;
   localparam int MAG_W = SQ_W + 1;
   localparam int unsigned EDGE_OFF = 1020;
   // chroma * 10000 < CHAN_MAX counts as no hue
   localparam int unsigned TINY_CHROMA = (CHAN_MAX - 1) / 10000 + 1;

   typedef enum logic [0:0] {
      CSR_EDGE_THRESHOLD = 1'b0,
      CSR_MONO_MODE      = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      COLOUR_WHITE   = 3'd0,
      COLOUR_RED     = 3'd1,
      COLOUR_YELLOW  = 3'd2,
      COLOUR_GREEN   = 3'd3,
      COLOUR_CYAN    = 3'd4,
      COLOUR_BLUE    = 3'd5,
      COLOUR_MAGENTA = 3'd6
   } colour_type;

   typedef enum logic [1:0] {
      MAX_RED   = 2'd0,
      MAX_GREEN = 2'd1,
      MAX_BLUE  = 2'd2
   } max_sel_type;

   localparam logic [6:0] GLYPH_UNDER  = 7'h5F;
   localparam logic [6:0] GLYPH_PIPE   = 7'h7C;
   localparam logic [6:0] GLYPH_BSLASH = 7'h5C;
   localparam logic [6:0] GLYPH_SLASH  = 7'h2F;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] vmax;
      logic [CHANNEL_BITS-1:0] chroma;
      max_sel_type             max_sel;
      logic signed [DIFF_W-1:0] diff;
   } pxa_hue_type;

   typedef struct packed {
      logic                ay_gt_ax;
      logic                ay_zero;
      logic                same_sign;
      logic [SQ_W-1:0]     ax2;
      logic [SQ_W-1:0]     dif2;
      logic [SUM_SQ_W-1:0] sum2;
   } pxa_edge_type;

   function automatic logic [6:0] ramp_glyph(input logic [3:0] idx);
      logic [6:0] g;
      case (idx)
         4'd0:    g = 7'h20;
         4'd1:    g = 7'h2E;
         4'd2:    g = 7'h2D;
         4'd3:    g = 7'h3D;
         4'd4:    g = 7'h2B;
         4'd5:    g = 7'h2A;
         4'd6:    g = 7'h78;
         4'd7:    g = 7'h23;
         4'd8:    g = 7'h24;
         4'd9:    g = 7'h26;
         4'd10:   g = 7'h58;
         4'd11:   g = 7'h40;
         default: g = 7'h40;
      endcase
      return g;
   endfunction

   // k * CHAN_MAX^2, the scaled boundary of shade entry k
   function automatic logic [SHADE_W-1:0] shade_limit(input logic [3:0] k);
      longint unsigned lim;
      lim = longint'(k) * longint'(CHAN_MAX) * longint'(CHAN_MAX);
      return SHADE_W'(lim);
   endfunction

endpackage

### rtl/pixel_to_ascii_glyph_colour_unit.sv
// Top level: pixel to ASCII glyph and colour code, three-stage pipeline.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    red, green, blue, grad_x, grad_y
//   rsp      out        rsp_valid/ready    glyph, colour
//   csr      in         csr_wr_en          csr_index, csr_wr_data
//
// One request per clock while no response stalls; the rate is set by the
// stage-to-stage handshake, with every stage a register of its own.
// Reset (synchronous) clears stage valid bits and loads threshold 1020
// and colour mode. A stage takes new data when it is empty or the stage
// after it moves, so a stalled result holds while bubbles ahead close up.
module pixel_to_ascii_glyph_colour_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic signed [10:0] req_grad_x,
   input  logic signed [10:0] req_grad_y,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_glyph,
   output logic [2:0]        rsp_colour,
   input  logic              csr_wr_en,
   input  logic [0:0]        csr_index,
   input  logic [10:0]       csr_wr_data
);
   import pxa_pkg::*;

   // configuration
   logic [THR_W-1:0]   edge_threshold_ff;
   logic               mono_mode_ff;
   logic [SQ_W-1:0]    thr_sq_ff;

   // stage enables
   logic en1, en2, en3;

   // stage 1: channel max/min, hue terms, gradient magnitudes
   logic                     s1_valid_ff;
   pxa_hue_type              s1_hue_ff, s1_hue_in;
   logic [CHANNEL_BITS-1:0]  s1_red_ff, s1_red_in;
   logic                     s1_mono_ff;
   logic [GRAD_W-1:0]        s1_ax_ff, s1_ax_in;
   logic [GRAD_W-1:0]        s1_ay_ff, s1_ay_in;
   logic [GRAD_W-1:0]        s1_dif_ff, s1_dif_in;
   logic [SUM_W-1:0]         s1_sum_ff, s1_sum_in;
   logic                     s1_gt_ff, s1_gt_in;
   logic                     s1_same_ff, s1_same_in;

   // stage 2: squares, colour decided
   logic                     s2_valid_ff;
   colour_type               s2_colour_ff, s2_colour_in;
   logic [BASE_W-1:0]        s2_base_ff, s2_base_in;
   pxa_edge_type             s2_edge_ff, s2_edge_in;
   logic [SQ_W-1:0]          s2_ay2_ff, s2_ay2_in;

   // stage 3: output register
   logic                     s3_valid_ff;
   logic [6:0]               s3_glyph_ff, s3_glyph_in;
   colour_type               s3_colour_ff;

   colour_type               hue_colour;
   logic [6:0]               edge_glyph;

   assign en3 = !s3_valid_ff || rsp_ready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ready = en1;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_threshold_ff <= THR_W'(EDGE_OFF);
         mono_mode_ff      <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_EDGE_THRESHOLD: edge_threshold_ff <= csr_wr_data;
            CSR_MONO_MODE:      mono_mode_ff      <= csr_wr_data[0];
            default:            ;
         endcase
      end
   end

   // squared threshold is registered, following the register in the next cycle
   always_ff @(posedge clock) begin
      thr_sq_ff <= edge_threshold_ff * edge_threshold_ff;
   end

   // ---------------- stage 1 ----------------
   always_comb begin
      logic [CHANNEL_BITS-1:0] r, g, b, vmin;
      logic                    edge_off;
      logic                    gx_pos, gy_pos;
      r = CHANNEL_BITS'(req_red);
      g = CHANNEL_BITS'(req_green);
      b = CHANNEL_BITS'(req_blue);
      s1_red_in = r;

      if (r >= g && r >= b) begin
         s1_hue_in.max_sel = MAX_RED;
         s1_hue_in.vmax    = r;
         s1_hue_in.diff    = DIFF_W'(signed'({2'b00, g}) - signed'({2'b00, b})) <<< 1;
      end else if (g >= r && g >= b) begin
         s1_hue_in.max_sel = MAX_GREEN;
         s1_hue_in.vmax    = g;
         s1_hue_in.diff    = DIFF_W'(signed'({2'b00, b}) - signed'({2'b00, r})) <<< 1;
      end else begin
         s1_hue_in.max_sel = MAX_BLUE;
         s1_hue_in.vmax    = b;
         s1_hue_in.diff    = DIFF_W'(signed'({2'b00, r}) - signed'({2'b00, g})) <<< 1;
      end
      vmin = r;
      if (g < vmin) vmin = g;
      if (b < vmin) vmin = b;
      s1_hue_in.chroma = s1_hue_in.vmax - vmin;

      // edges disabled: both gradients count as zero
      edge_off = (edge_threshold_ff >= THR_W'(EDGE_OFF));
      if (edge_off) begin
         s1_ax_in = '0;
         s1_ay_in = '0;
         gx_pos   = 1'b0;
         gy_pos   = 1'b0;
      end else begin
         s1_ax_in = req_grad_x[GRAD_W-1] ? GRAD_W'(-req_grad_x) : GRAD_W'(req_grad_x);
         s1_ay_in = req_grad_y[GRAD_W-1] ? GRAD_W'(-req_grad_y) : GRAD_W'(req_grad_y);
         gx_pos   = !req_grad_x[GRAD_W-1] && (req_grad_x != '0);
         gy_pos   = !req_grad_y[GRAD_W-1] && (req_grad_y != '0);
      end
      s1_gt_in   = s1_ay_in > s1_ax_in;
      s1_dif_in  = s1_ay_in - s1_ax_in;
      s1_sum_in  = SUM_W'(s1_ay_in) + SUM_W'(s1_ax_in);
      s1_same_in = (gx_pos == gy_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_hue_ff  <= s1_hue_in;
         s1_red_ff  <= s1_red_in;
         s1_mono_ff <= mono_mode_ff;
         s1_ax_ff   <= s1_ax_in;
         s1_ay_ff   <= s1_ay_in;
         s1_dif_ff  <= s1_dif_in;
         s1_sum_ff  <= s1_sum_in;
         s1_gt_ff   <= s1_gt_in;
         s1_same_ff <= s1_same_in;
      end
   end

   // ---------------- stage 2 ----------------
   pxa_hue_sector u_hue (
      .hue    (s1_hue_ff),
      .colour (hue_colour)
   );

   always_comb begin
      s2_colour_in = s1_mono_ff ? COLOUR_WHITE : hue_colour;
      // mono: red * CHAN_MAX puts gray on the same scale as value squared
      if (s1_mono_ff) begin
         s2_base_in = {s1_red_ff, {CHANNEL_BITS{1'b0}}} - BASE_W'(s1_red_ff);
      end else begin
         s2_base_in = s1_hue_ff.vmax * s1_hue_ff.vmax;
      end
      s2_ay2_in            = s1_ay_ff * s1_ay_ff;
      s2_edge_in.ax2       = s1_ax_ff * s1_ax_ff;
      s2_edge_in.dif2      = s1_dif_ff * s1_dif_ff;
      s2_edge_in.sum2      = s1_sum_ff * s1_sum_ff;
      s2_edge_in.ay_gt_ax  = s1_gt_ff;
      s2_edge_in.ay_zero   = (s1_ay_ff == '0);
      s2_edge_in.same_sign = s1_same_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_colour_ff <= s2_colour_in;
         s2_base_ff   <= s2_base_in;
         s2_edge_ff   <= s2_edge_in;
         s2_ay2_ff    <= s2_ay2_in;
      end
   end

   // ---------------- stage 3 ----------------
   pxa_edge_sector u_edge (
      .edge_in (s2_edge_ff),
      .glyph   (edge_glyph)
   );

   always_comb begin
      logic [SHADE_W-1:0] shade_num;
      logic [3:0]         idx;
      logic [MAG_W-1:0]   mag;
      // 12 * base, compared against each shade boundary; count is the index
      shade_num = (SHADE_W'(s2_base_ff) << 3) + (SHADE_W'(s2_base_ff) << 2);
      idx = '0;
      for (int k = 1; k < RAMP_LEN; k++) begin
         idx = idx + 4'(shade_num >= shade_limit(4'(k)));
      end
      mag = MAG_W'(s2_edge_ff.ax2) + MAG_W'(s2_ay2_ff);
      if (mag >= MAG_W'(thr_sq_ff)) begin
         s3_glyph_in = edge_glyph;
      end else begin
         s3_glyph_in = ramp_glyph(idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_glyph_ff  <= s3_glyph_in;
         s3_colour_ff <= s2_colour_ff;
      end
   end

   assign rsp_valid  = s3_valid_ff;
   assign rsp_glyph  = s3_glyph_ff;
   assign rsp_colour = s3_colour_ff;

endmodule

### rtl/pxa_hue_sector.sv
// Colour pick from value, chroma and hue sector difference.
module pxa_hue_sector (
   input  pxa_pkg::pxa_hue_type hue,
   output pxa_pkg::colour_type  colour
);
   import pxa_pkg::*;

   logic signed [DIFF_W-1:0] c_s;
   logic                     low_sat;

   assign c_s = signed'({2'b00, hue.chroma});
   assign low_sat = (hue.vmax == '0) ||
                    ({hue.chroma, 2'b00} < {2'b00, hue.vmax});

   always_comb begin
      colour = COLOUR_WHITE;
      if (low_sat) begin
         colour = COLOUR_WHITE;
      end else if (hue.chroma < CHANNEL_BITS'(TINY_CHROMA)) begin
         colour = COLOUR_RED;
      end else begin
         case (hue.max_sel)
            MAX_RED: begin
               colour = (hue.diff >= c_s) ? COLOUR_YELLOW : COLOUR_RED;
            end
            MAX_GREEN: begin
               if (hue.diff < -c_s)     colour = COLOUR_YELLOW;
               else if (hue.diff < c_s) colour = COLOUR_GREEN;
               else                     colour = COLOUR_CYAN;
            end
            default: begin
               if (hue.diff < -c_s)     colour = COLOUR_CYAN;
               else if (hue.diff < c_s) colour = COLOUR_BLUE;
               else                     colour = COLOUR_MAGENTA;
            end
         endcase
      end
   end

endmodule

### rtl/pxa_edge_sector.sv
// Edge glyph from gradient direction, compared through squared terms.
module pxa_edge_sector (
   input  pxa_pkg::pxa_edge_type edge_in,
   output logic [6:0]            glyph
);
   import pxa_pkg::*;

   logic [SUM_SQ_W-1:0] two_x2;

   assign two_x2 = SUM_SQ_W'({edge_in.ax2, 1'b0});

   always_comb begin
      if (edge_in.ay_gt_ax && (SUM_SQ_W'(edge_in.dif2) > two_x2)) begin
         glyph = GLYPH_UNDER;
      end else if (edge_in.ay_zero || (edge_in.sum2 < two_x2)) begin
         glyph = GLYPH_PIPE;
      end else if (edge_in.same_sign) begin
         glyph = GLYPH_BSLASH;
      end else begin
         glyph = GLYPH_SLASH;
      end
   end

endmodule

### tb/sv/tb.sv
// Testbench for the pixel to ASCII glyph and colour unit: self-checking, randomized.
`timescale 1ns / 100ps

module tb;
   import pxa_pkg::*;

   // ---------------------------------------------------------------------
   // Types
   // ---------------------------------------------------------------------
   // One pixel request as driven onto the req_ ports.
   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic signed [10:0] grad_x;
      logic signed [10:0] grad_y;
   } pixel_type;

   // One predicted text cell: glyph and colour.
   typedef struct packed {
      logic [6:0] glyph;
      colour_type colour;
   } cell_type;

   localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the pipe
   localparam int SETTLE_TICKS = 6;    // pipe is three deep; a little slack
   localparam int PRINT_CAP    = 20;   // mismatch lines printed before going quiet

   // ---------------------------------------------------------------------
   // Clock, reset and DUT ports (every input starts at a known value)
   // ---------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_red = '0;
   logic [7:0]         req_green = '0;
   logic [7:0]         req_blue = '0;
   logic signed [10:0] req_grad_x = '0;
   logic signed [10:0] req_grad_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [6:0]         rsp_glyph;
   logic [2:0]         rsp_colour;
   logic               csr_wr_en = 1'b0;
   logic [0:0]         csr_index = '0;
   logic [10:0]        csr_wr_data = '0;

   pixel_to_ascii_glyph_colour_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .req_grad_x  (req_grad_x),
      .req_grad_y  (req_grad_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_glyph   (rsp_glyph),
      .rsp_colour  (rsp_colour),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------
   pixel_type   pending_pixels[$];     // requests not yet put on the bus
   cell_type    predicted_cells[$];    // expected responses, oldest first
   logic [10:0] cfg_threshold = 11'd1020;  // shadow of the CSRs (reset values)
   logic        cfg_mono = 1'b0;
   int          send_idle_pct = 0;     // sender idles this many cycles in 100
   int          recv_stall_pct = 0;    // receiver stalls this many in 100
   bit          hold_req = 1'b0;       // asks the receiver for a long hold-off
   int          hold_left = 0;
   bit          req_taken = 1'b0;      // request accepted at the last rising edge
   int          error_count = 0;
   int          cells_checked = 0;
   int          edge_cells = 0;
   int          mono_cells = 0;
   int          csr_writes = 0;
   pixel_type   seen_pixel;
   cell_type    want_cell;

   // ---------------------------------------------------------------------
   // Predictor: pixel + current CSRs -> glyph and colour
   // ---------------------------------------------------------------------
   function automatic cell_type predict_cell(pixel_type p, logic [10:0] thr, logic mono);
      string    ramp_chars;
      int       r, g, b, vmax, vmin, chroma, idx, d;
      int       gx, gy, ax, ay, t;
      cell_type res;
      ramp_chars = " .-=+*x#$&X@";
      r = p.red;
      g = p.green;
      b = p.blue;
      gx = p.grad_x;
      gy = p.grad_y;
      res.colour = COLOUR_WHITE;
      if (mono) begin
         idx = (RAMP_LEN * r) / int'(CHAN_MAX);
      end else begin
         // max picks red, then green, then blue on ties
         if (r >= g && r >= b) begin
            vmax = r;
         end else if (g >= r && g >= b) begin
            vmax = g;
         end else begin
            vmax = b;
         end
         vmin = (r < g) ? r : g;
         if (b < vmin) begin
            vmin = b;
         end
         chroma = vmax - vmin;
         idx = (RAMP_LEN * vmax * vmax) / (int'(CHAN_MAX) * int'(CHAN_MAX));
         // hue sectors by cross-multiplication; saturation < 1/4 is white
         if (vmax == 0 || 4 * chroma < vmax) begin
            res.colour = COLOUR_WHITE;
         end else if (chroma * 10000 < int'(CHAN_MAX)) begin
            res.colour = COLOUR_RED;
         end else if (r >= g && r >= b) begin
            res.colour = (2 * (g - b) >= chroma) ? COLOUR_YELLOW : COLOUR_RED;
         end else if (g >= r && g >= b) begin
            d = 2 * (b - r);
            if (d < -chroma) begin
               res.colour = COLOUR_YELLOW;
            end else if (d < chroma) begin
               res.colour = COLOUR_GREEN;
            end else begin
               res.colour = COLOUR_CYAN;
            end
         end else begin
            d = 2 * (r - g);
            if (d < -chroma) begin
               res.colour = COLOUR_CYAN;
            end else if (d < chroma) begin
               res.colour = COLOUR_BLUE;
            end else begin
               res.colour = COLOUR_MAGENTA;
            end
         end
      end
      if (idx >= RAMP_LEN) begin
         idx = RAMP_LEN - 1;
      end
      res.glyph = 7'(ramp_chars[idx]);

      // edge override; threshold at or above 4.0 zeroes the gradients
      if (thr >= EDGE_OFF) begin
         gx = 0;
         gy = 0;
      end
      t = thr;
      if (gx * gx + gy * gy >= t * t) begin
         ax = (gx < 0) ? -gx : gx;
         ay = (gy < 0) ? -gy : gy;
         if (ay > ax && (ay - ax) * (ay - ax) > 2 * ax * ax) begin
            res.glyph = GLYPH_UNDER;
         end else if (ay == 0 || (ay + ax) * (ay + ax) < 2 * ax * ax) begin
            res.glyph = GLYPH_PIPE;
         end else if ((gx > 0) == (gy > 0)) begin
            res.glyph = GLYPH_BSLASH;
         end else begin
            res.glyph = GLYPH_SLASH;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and run limit
   // ---------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: a run still going at this time limit ends in failure.
   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Mismatch reporting: one line each, printing capped, always counted
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      if (error_count < PRINT_CAP) begin
         $display("tb: mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      end
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: samples both handshakes at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         // response side first: the output is registered, so it never belongs to this edge's request
         if (rsp_valid && rsp_ready) begin
            if (predicted_cells.size() == 0) begin
               report_mismatch("unexpected response, glyph", rsp_glyph, 0);
            end else begin
               want_cell = predicted_cells.pop_front();
               if (rsp_glyph !== want_cell.glyph) begin
                  report_mismatch("glyph", rsp_glyph, want_cell.glyph);
               end
               if (rsp_colour !== want_cell.colour) begin
                  report_mismatch("colour", rsp_colour, want_cell.colour);
               end
               cells_checked++;
               if (want_cell.glyph inside {GLYPH_UNDER, GLYPH_PIPE, GLYPH_BSLASH,
                                           GLYPH_SLASH}) begin
                  edge_cells++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            seen_pixel.red = req_red;
            seen_pixel.green = req_green;
            seen_pixel.blue = req_blue;
            seen_pixel.grad_x = req_grad_x;
            seen_pixel.grad_y = req_grad_y;
            predicted_cells.push_back(predict_cell(seen_pixel, cfg_threshold, cfg_mono));
            if (cfg_mono) begin
               mono_cells++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: offers pending pixels at the falling edge, holds until taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      pixel_type next_px;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_px = pending_pixels.pop_front();
            req_valid  <= 1'b1;
            req_red    <= next_px.red;
            req_green  <= next_px.green;
            req_blue   <= next_px.blue;
            req_grad_x <= next_px.grad_x;
            req_grad_y <= next_px.grad_y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a counted long hold-off on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_pixel(int r, int g, int b, int gx, int gy);
      pixel_type px;
      px.red = 8'(r);
      px.green = 8'(g);
      px.blue = 8'(b);
      px.grad_x = 11'(gx);
      px.grad_y = 11'(gy);
      pending_pixels.push_back(px);
   endtask

   // Sender pause: nothing queued, nothing offered, nothing outstanding.
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || predicted_cells.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // CSR write, only ever issued with the pipe empty.
   task automatic write_csr(csr_index_type idx, logic [10:0] data);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_EDGE_THRESHOLD) begin
         cfg_threshold = data;
      end else begin
         cfg_mono = data[0];
      end
      csr_writes++;
   endtask

   function automatic int rand_grad(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Random pixel: mix of colour shapes and gradient shapes.
   task automatic add_random_pixel();
      int r, g, b, v, lo, gx, gy, m;
      r = $urandom_range(255);
      g = $urandom_range(255);
      b = $urandom_range(255);
      case ($urandom_range(5))
         0: begin   // gray
            g = r;
            b = r;
         end
         1: begin   // near gray
            g = r + rand_grad(-3, 3);
            b = r + rand_grad(-3, 3);
            g = (g < 0) ? 0 : (g > 255) ? 255 : g;
            b = (b < 0) ? 0 : (b > 255) ? 255 : b;
         end
         2: begin   // extremes and ties
            r = $urandom_range(1) ? 255 : 0;
            g = $urandom_range(2) == 0 ? r : ($urandom_range(1) ? 255 : 0);
            b = $urandom_range(2) == 0 ? g : $urandom_range(255);
         end
         3: begin   // around the quarter-saturation line
            v = $urandom_range(255);
            lo = v - v / 4 + rand_grad(-1, 1);
            lo = (lo < 0) ? 0 : (lo > v) ? v : lo;
            r = v;
            g = lo;
            b = lo + $urandom_range(v - lo);
            m = $urandom_range(2);
            if (m == 1) begin
               r = b; b = v;
            end else if (m == 2) begin
               r = g; g = v;
            end
         end
         default: ;
      endcase
      case ($urandom_range(4))
         0: begin   // full range
            gx = rand_grad(-1020, 1020);
            gy = rand_grad(-1020, 1020);
         end
         1: begin   // moderate, straddles most thresholds
            gx = rand_grad(-400, 400);
            gy = rand_grad(-400, 400);
         end
         2: begin   // one axis zero
            gx = rand_grad(-1020, 1020);
            gy = 0;
            if ($urandom_range(1)) begin
               gy = gx; gx = 0;
            end
         end
         3: begin   // near diagonal, random signs
            gx = rand_grad(0, 700);
            gy = gx + rand_grad(-gx / 2, gx / 2);
            gx = $urandom_range(1) ? -gx : gx;
            gy = $urandom_range(1) ? -gy : gy;
         end
         default: begin
            gx = 0;
            gy = 0;
         end
      endcase
      add_pixel(r, g, b, gx, gy);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int thr_list[10];
      int seg;
      thr_list = '{0, 37, 2047, 150, 1019, 400, 1020, 1, 700, 90};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset CSRs (edges off, colour): hue sectors, ties, clamp
      add_pixel(0, 0, 0, 1020, -1020);       // black -> white, edges ignored
      add_pixel(255, 255, 255, -1020, 1020); // full brightness clamps shade
      add_pixel(200, 50, 150, 0, 0);         // red max, negative hue stays red
      add_pixel(200, 180, 0, 0, 0);          // red max -> yellow
      add_pixel(150, 200, 0, 0, 0);          // green max -> yellow
      add_pixel(0, 200, 0, 0, 0);            // green
      add_pixel(0, 200, 180, 0, 0);          // green max -> cyan
      add_pixel(0, 150, 200, 0, 0);          // blue max -> cyan
      add_pixel(0, 0, 200, 0, 0);            // blue
      add_pixel(180, 0, 200, 0, 0);          // blue max -> magenta
      add_pixel(200, 200, 0, 0, 0);          // red/green tie, red wins
      add_pixel(0, 200, 200, 0, 0);          // green/blue tie, green wins
      add_pixel(200, 180, 170, 0, 0);        // low saturation -> white
      add_pixel(4, 3, 3, 0, 0);              // tiny chroma, saturation exactly 1/4

      // Zero threshold, mono: every pixel is an edge
      write_csr(CSR_EDGE_THRESHOLD, 11'd0);
      write_csr(CSR_MONO_MODE, 1'b1);
      add_pixel(0, 77, 200, 0, 0);           // zero gradient -> pipe
      add_pixel(255, 0, 0, 0, 500);          // near vertical -> underscore
      add_pixel(254, 0, 0, 500, 0);          // horizontal -> pipe
      add_pixel(128, 9, 9, 300, 300);        // same sign -> backslash
      add_pixel(128, 9, 9, -300, 300);       // opposite sign -> slash
      add_pixel(128, 9, 9, -300, -300);
      add_pixel(1, 255, 255, 1020, -1020);

      // Mid threshold, colour: just below and at the threshold
      write_csr(CSR_EDGE_THRESHOLD, 11'd400);
      write_csr(CSR_MONO_MODE, 1'b0);
      add_pixel(10, 200, 30, 300, 200);      // below threshold
      add_pixel(10, 200, 30, 400, 0);        // exactly on threshold
      add_pixel(255, 0, 0, -283, 283);
      add_pixel(0, 0, 0, -1020, -1020);

      // Random segments, each with its own CSRs and idle pattern
      for (seg = 0; seg < 10; seg++) begin
         write_csr(CSR_EDGE_THRESHOLD, 11'(thr_list[seg]));
         write_csr(CSR_MONO_MODE, 1'(seg % 3 == 1));
         case (seg % 4)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 77; recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 77;
            end
            default: begin
               send_idle_pct = 24; recv_stall_pct = 24;
            end
         endcase
         // receiver blocks while the sender keeps offering: pipe fills, req stalls
         if (seg == 4) begin
            hold_req = 1'b1;
         end
         repeat (125) add_random_pixel();
      end

      // Drain, then watch for stray responses
      wait_idle();
      repeat (SETTLE_TICKS) @(negedge clock);

      $display("tb: %0d cells checked, %0d edge glyphs, %0d in mono mode",
               cells_checked, edge_cells, mono_cells);
      $display("tb: %0d CSR writes, thresholds 0 to 2047, all idle/stall mixes",
               csr_writes);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
rtl/pxa_pkg.sv
rtl/pxa_hue_sector.sv
rtl/pxa_edge_sector.sv
rtl/pixel_to_ascii_glyph_colour_unit.sv
tb/sv/tb.sv
